FILE: rtl/hw2d_pkg.sv
// ----------------------------------------------------------------------------
// hw2d_pkg: shared types and constants of the 2-D Haar wavelet stream
// Payload structs of both channels, pixel and job types, register indexes
// and the default frame limits.
// ----------------------------------------------------------------------------
package hw2d_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int POS_W    = 9;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 2;

  // Default limits of the frame geometry.
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Four results leave per pixel pair on an odd row.
  localparam int NUM_RES = 4;
  localparam int SEL_W   = 2;
  localparam logic [SEL_W-1:0] SEL_FIRST = 2'd0;
  localparam logic [SEL_W-1:0] SEL_LAST  = 2'd3;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

  typedef struct packed {
    chan_t chan0;
    chan_t chan1;
    chan_t chan2;
  } in_t;

  typedef struct packed {
    pos_t  out_row;
    pos_t  out_col;
    chan_t res0;
    chan_t res1;
    chan_t res2;
    logic  run_end;
  } out_t;

  // One vertical job: row-transformed pair of the odd row and its positions.
  typedef struct packed {
    pos_t r0;
    pos_t r1;
    pos_t c0;
    pos_t c1;
    pix_t lo;
    pix_t hi;
  } job_t;

endpackage

FILE: rtl/hw2d_lane.sv
// ----------------------------------------------------------------------------
// hw2d_lane: one channel of the Haar pair rule
// Gives low = floor((a + b) / 2) and high = |low - a| for one 8-bit channel.
// ----------------------------------------------------------------------------
module hw2d_lane (
  input  hw2d_pkg::chan_t a_i,
  input  hw2d_pkg::chan_t b_i,
  output hw2d_pkg::chan_t low_o,
  output hw2d_pkg::chan_t high_o
);

  logic [hw2d_pkg::CHAN_W:0] sum;

  // The sum keeps its carry so the halving is exact.
  assign sum   = {1'b0, a_i} + {1'b0, b_i};
  assign low_o = sum[hw2d_pkg::CHAN_W:1];

  // Absolute difference against the first operand.
  assign high_o = (low_o >= a_i) ? (low_o - a_i) : (a_i - low_o);

endmodule

FILE: rtl/hw2d_line_buf.sv
// ----------------------------------------------------------------------------
// hw2d_line_buf: line buffer of row-transformed pixels
// One write port and two registered read ports over one row of pixels.
// ----------------------------------------------------------------------------
module hw2d_line_buf #(
  parameter int DEPTH = hw2d_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  hw2d_pkg::pix_t           wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output hw2d_pkg::pix_t           rdata0_o,
  output hw2d_pkg::pix_t           rdata1_o
);

  hw2d_pkg::pix_t mem [DEPTH];
  hw2d_pkg::pix_t rdata0_q;
  hw2d_pkg::pix_t rdata1_q;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Both reads are registered and hold until the next read request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

FILE: rtl/hw2d_merge.sv
// ----------------------------------------------------------------------------
// hw2d_merge: vertical stage and result sequencer
// Runs the vertical Haar rule in three channel lanes and merges the lanes
// into the four quadrant results, which leave one per cycle unless stalled.
// ----------------------------------------------------------------------------
module hw2d_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  hw2d_pkg::job_t   job_i,
  output logic             job_ready_o,
  input  hw2d_pkg::pix_t   top_lo_i,
  input  hw2d_pkg::pix_t   top_hi_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hw2d_pkg::out_t   out_o
);

  hw2d_pkg::job_t job_q;
  hw2d_pkg::out_t res_q [hw2d_pkg::NUM_RES];
  hw2d_pkg::out_t res_d [hw2d_pkg::NUM_RES];
  logic pend_q, pend_d;
  logic busy_q, busy_d;
  logic [hw2d_pkg::SEL_W-1:0] sel_q, sel_d;
  logic out_fire, load, job_take;
  hw2d_pkg::pix_t ll, lh, hl, hh;

  // Handshake of the result buffer and of the pending job.
  assign out_fire    = busy_q & ~out_stall_i;
  assign load        = pend_q & (~busy_q | (out_fire & (sel_q == hw2d_pkg::SEL_LAST)));
  assign job_ready_o = ~pend_q | load;
  assign job_take    = job_valid_i & job_ready_o;

  // Vertical lanes: the stored top row plays the first operand.
  for (genvar k = 0; k < hw2d_pkg::NUM_CHAN; k++) begin : g_lane
    hw2d_lane u_low (
      .a_i    (top_lo_i[k]),
      .b_i    (job_q.lo[k]),
      .low_o  (ll[k]),
      .high_o (lh[k])
    );
    hw2d_lane u_high (
      .a_i    (top_hi_i[k]),
      .b_i    (job_q.hi[k]),
      .low_o  (hl[k]),
      .high_o (hh[k])
    );
  end

  // Merge the lanes into the quadrant results in output order.
  always_comb begin
    res_d[0].out_row = job_q.r0;
    res_d[0].out_col = job_q.c0;
    res_d[0].res0    = ll[0];
    res_d[0].res1    = ll[1];
    res_d[0].res2    = ll[2];
    res_d[0].run_end = 1'b0;
    res_d[1].out_row = job_q.r0;
    res_d[1].out_col = job_q.c1;
    res_d[1].res0    = hl[0];
    res_d[1].res1    = hl[1];
    res_d[1].res2    = hl[2];
    res_d[1].run_end = 1'b0;
    res_d[2].out_row = job_q.r1;
    res_d[2].out_col = job_q.c0;
    res_d[2].res0    = lh[0];
    res_d[2].res1    = lh[1];
    res_d[2].res2    = lh[2];
    res_d[2].run_end = 1'b0;
    res_d[3].out_row = job_q.r1;
    res_d[3].out_col = job_q.c1;
    res_d[3].res0    = hh[0];
    res_d[3].res1    = hh[1];
    res_d[3].res2    = hh[2];
    res_d[3].run_end = 1'b1;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (job_take) begin
      job_q <= job_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  // Next state of the pending flag and the result sequencer.
  always_comb begin
    pend_d = pend_q;
    busy_d = busy_q;
    sel_d  = sel_q;
    if (job_take) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      sel_d  = hw2d_pkg::SEL_FIRST;
    end else if (out_fire) begin
      sel_d = sel_q + 1'b1;
      if (sel_q == hw2d_pkg::SEL_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      busy_q <= 1'b0;
      sel_q  <= hw2d_pkg::SEL_FIRST;
    end else begin
      pend_q <= pend_d;
      busy_q <= busy_d;
      sel_q  <= sel_d;
    end
  end

  assign out_valid_o = busy_q;
  assign out_o       = res_q[sel_q];

endmodule

FILE: rtl/haar_wavelet_2d_stream.sv
// ----------------------------------------------------------------------------
// haar_wavelet_2d_stream: one-level 2-D Haar wavelet on a pixel stream
// Pixels of three 8-bit channels enter in raster order; the four quadrant
// results of every 2x2 block leave with their positions in the frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_i) takes one pixel per request.
//   Output channel (out_valid_o, out_stall_i, out_o) gives one result per
//   request; run_end marks the fourth result of a pixel pair.
//   Configuration channel (cfg_valid_i, cfg_ready_o) writes frame_width at
//   index 0 and frame_height at index 1; write only while the block is idle.
//   Even rows are stored in the line buffer, one pixel per cycle, no results.
//   On an odd row the second pixel of each pair yields four results; the
//   job and the line buffer read are registered, then the results are loaded
//   into the result buffer once it is free, and offered from there. The rate
//   on odd rows is bounded by the single result port that drains four results
//   per pair; the next pair's first pixel is taken while they still leave.
//   While the receiver stalls, the current result holds and the input stalls
//   once one further pixel pair is waiting on the result buffer.
//   Reset clears the counters, the size registers to 512 and the result
//   sequencer; the line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module haar_wavelet_2d_stream #(
  parameter int MAX_WIDTH  = hw2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hw2d_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hw2d_pkg::in_t                   in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hw2d_pkg::out_t                  out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hw2d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hw2d_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int RB  = $clog2(MAX_HEIGHT);
  localparam int SW  = $clog2(MAX_WIDTH + 1);
  localparam int SH  = $clog2(MAX_HEIGHT + 1);
  localparam int CWW = (SW > hw2d_pkg::CFG_W) ? SW : hw2d_pkg::CFG_W;
  localparam int CWH = (SH > hw2d_pkg::CFG_W) ? SH : hw2d_pkg::CFG_W;
  localparam int XW0 = (SW > SH) ? SW : SH;
  localparam int XW  = (XW0 > hw2d_pkg::POS_W) ? XW0 : hw2d_pkg::POS_W;

  logic [hw2d_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
  logic [CB-1:0] col_q, col_d;
  logic [RB-1:0] row_q, row_d;
  hw2d_pkg::pix_t held_q;
  logic wr2_q;
  logic [CB-1:0] wr2_addr_q;
  hw2d_pkg::pix_t wr2_data_q;

  logic [CWW-1:0] fw_clamp;
  logic [CWH-1:0] fh_clamp;
  logic [SW-1:0] eff_w;
  logic [SH-1:0] eff_h;
  logic [CB-1:0] pair_m, addr_lo, addr_hi;
  logic [XW-1:0] col_hi_ext, row_hi_ext;
  hw2d_pkg::pix_t pix, lo, hi, top_lo, top_hi;
  hw2d_pkg::job_t job;
  logic odd_col, odd_row, in_fire, job_valid, job_ready, pair_store;
  logic mem_we;
  logic [CB-1:0] mem_waddr;
  hw2d_pkg::pix_t mem_wdata;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= hw2d_pkg::SIZE_RESET;
      frame_height_q <= hw2d_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hw2d_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        hw2d_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size: clamped to the legal range and made even.
  always_comb begin
    fw_clamp = CWW'(frame_width_q);
    if (fw_clamp < CWW'(2)) begin
      fw_clamp = CWW'(2);
    end else if (fw_clamp > CWW'(MAX_WIDTH)) begin
      fw_clamp = CWW'(MAX_WIDTH);
    end
    fh_clamp = CWH'(frame_height_q);
    if (fh_clamp < CWH'(2)) begin
      fh_clamp = CWH'(2);
    end else if (fh_clamp > CWH'(MAX_HEIGHT)) begin
      fh_clamp = CWH'(MAX_HEIGHT);
    end
    eff_w = SW'(fw_clamp) & ~SW'(1);
    eff_h = SH'(fh_clamp) & ~SH'(1);
  end

  // Input handshake: only a pair end on an odd row can wait.
  assign odd_col    = col_q[0];
  assign odd_row    = row_q[0];
  assign in_stall_o = odd_col & odd_row & ~job_ready;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign job_valid  = in_fire & odd_col & odd_row;
  assign pair_store = in_fire & odd_col & ~odd_row;

  assign pix[0] = in_i.chan0;
  assign pix[1] = in_i.chan1;
  assign pix[2] = in_i.chan2;

  // Horizontal lanes, one per channel.
  for (genvar k = 0; k < hw2d_pkg::NUM_CHAN; k++) begin : g_lane
    hw2d_lane u_lane (
      .a_i    (held_q[k]),
      .b_i    (pix[k]),
      .low_o  (lo[k]),
      .high_o (hi[k])
    );
  end

  // Line buffer addresses and output positions of the pair.
  assign pair_m     = col_q >> 1;
  assign addr_lo    = pair_m;
  assign addr_hi    = CB'(SW'(eff_w >> 1) + SW'(pair_m));
  assign col_hi_ext = XW'(eff_w >> 1) + XW'(pair_m);
  assign row_hi_ext = XW'(eff_h >> 1) + XW'(row_q >> 1);

  always_comb begin
    job.r0 = hw2d_pkg::POS_W'(XW'(row_q >> 1));
    job.r1 = row_hi_ext[hw2d_pkg::POS_W-1:0];
    job.c0 = hw2d_pkg::POS_W'(XW'(pair_m));
    job.c1 = col_hi_ext[hw2d_pkg::POS_W-1:0];
    job.lo = lo;
    job.hi = hi;
  end

  // Column and row counters with wrap at the frame size.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if ((SW'(col_q) + SW'(1)) >= eff_w) begin
        col_d = '0;
        if ((SH'(row_q) + SH'(1)) >= eff_h) begin
          row_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
        if (SH'(row_q) >= eff_h) begin
          row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
      wr2_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      wr2_q <= pair_store;
      if (in_fire & ~odd_col) begin
        held_q <= pix;
      end
    end
  end

  // The high half of an even-row pair is written in the cycle after the low half.
  always_ff @(posedge clk_i) begin
    if (pair_store) begin
      wr2_addr_q <= addr_hi;
      wr2_data_q <= hi;
    end
  end

  assign mem_we    = pair_store | wr2_q;
  assign mem_waddr = wr2_q ? wr2_addr_q : addr_lo;
  assign mem_wdata = wr2_q ? wr2_data_q : lo;

  hw2d_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .re_i     (job_valid),
    .raddr0_i (addr_lo),
    .raddr1_i (addr_hi),
    .rdata0_o (top_lo),
    .rdata1_o (top_hi)
  );

  hw2d_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .top_lo_i    (top_lo),
    .top_hi_i    (top_hi),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/hw2d_checker.sv
// ----------------------------------------------------------------------------
// hw2d_checker: port-level checks of the 2-D Haar wavelet stream
// Watches the handshake ports and the result grouping over time.
// ----------------------------------------------------------------------------
module hw2d_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hw2d_pkg::out_t out_o
);

  // A result that is not the last of its group is followed at once by the next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_o.run_end) |=> out_valid_o)
  else $error("result group broken off");

  // The input waits only behind results that are being offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |-> out_valid_o)
  else $error("input stalled with no result pending");

  // No result is offered while reset is held.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
  else $error("result offered during reset");

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
  else $error("stalled result changed");

endmodule

bind haar_wavelet_2d_stream hw2d_checker u_hw2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
